### rtl/ott_pkg.sv
// Shared types, sizes and codes for the ordered timer table.
package ott_pkg;

   // Table geometry and arithmetic widths.
   localparam int NUM_SLOTS   = 16;
   localparam int TIME_BITS   = 48;
   localparam int PERIOD_BITS = 32;
   localparam int MAX_OUT     = 16;
   localparam int SLOT_BITS   = $clog2(NUM_SLOTS);
   localparam int CNT_BITS    = $clog2(NUM_SLOTS + 1);
   localparam int EMIT_BITS   = $clog2(MAX_OUT + 1);

   // Fixed port field widths.
   localparam int OP_W     = 3;
   localparam int NOW_W    = 48;
   localparam int PER_W    = 32;
   localparam int SLOTF_W  = 4;
   localparam int STATUS_W = 2;
   localparam int WAIT_W   = 48;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   // Operation codes of the request channel.
   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 3'd0,
      OP_CANCEL  = 3'd1,
      OP_RESET   = 3'd2,
      OP_PROCESS = 3'd3,
      OP_QUERY   = 3'd4
   } op_type;

   // Status codes of the response channel.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_FULL       = 2'd1,
      STAT_NOT_ACTIVE = 2'd2,
      STAT_NONE_DUE   = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ADD_WR,
      S_RST_START,
      S_RST_SUM,
      S_RST_CMP,
      S_MARK,
      S_PCHK,
      S_SCAN,
      S_EMIT_BE,
      S_QRY,
      S_UPD
   } fsm_type;

   // Shared add/subtract unit.
   typedef enum logic {
      ALU_ADD_SAT,
      ALU_SUB_CLAMP
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      logic [TIME_BITS-1:0] a;
      logic [TIME_BITS-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] value;
      logic                 lt;
      logic                 eq;
   } alu_res_type;

   // One slot of the timer memory.
   typedef struct packed {
      logic                   reload;
      logic [PERIOD_BITS-1:0] period;
      logic [TIME_BITS-1:0]   expiry;
   } entry_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      entry_type            data;
   } mem_wr_type;

   // One response transaction.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOTF_W-1:0]  slot_out;
      logic [WAIT_W-1:0]   wait_ms;
      logic                became_earliest;
      logic                last;
   } rsp_type;

endpackage

### rtl/ott_slot_mem.sv
// Slot memory: one write port, one registered read port.
module ott_slot_mem
   import ott_pkg::*;
(
   input  logic                 clock,
   input  mem_wr_type           wr,
   input  logic [SLOT_BITS-1:0] raddr,
   output entry_type            rd_data
);

   entry_type mem_ff [NUM_SLOTS];
   entry_type rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ott_alu.sv
// Shared adder: saturating add, clamped subtract and magnitude compare.
module ott_alu
   import ott_pkg::*;
(
   input  alu_req_type req,
   output alu_res_type res
);

   logic                 sub;
   logic [TIME_BITS-1:0] b_eff;
   logic [TIME_BITS:0]   sum;
   logic                 carry;

   // One adder serves both modes; subtract adds the complement plus one.
   always_comb begin
      sub   = (req.op == ALU_SUB_CLAMP);
      b_eff = sub ? ~req.b : req.b;
      sum   = {1'b0, req.a} + {1'b0, b_eff} + {{TIME_BITS{1'b0}}, sub};
      carry = sum[TIME_BITS];
   end

   // Add saturates on carry out; subtract clamps at zero when a is below b.
   always_comb begin
      if (sub) begin
         res.value = carry ? sum[TIME_BITS-1:0] : '0;
      end else begin
         res.value = carry ? TIME_MAX : sum[TIME_BITS-1:0];
      end
      res.lt = sub & ~carry;
      res.eq = sub & carry & (sum[TIME_BITS-1:0] == '0);
   end

endmodule

### rtl/ordered_timer_table_top.sv
// Ordered timer table: sequencer, slot valid bits and response register.
// Every scan of the table reads all slots in turn through one read port.
// Add runs decode, write, scan and emit; reset runs decode, start, sum, compare and scan.
// Process marks expired slots in one scan, then scans again for each expired slot emitted.
// Cancel and rejected requests are answered from the decode state; one request is in flight.
// Synchronous active-high reset clears all slots to free and the response channel to idle.
module ordered_timer_table_top
   import ott_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [NOW_W-1:0]    req_now_ms,
   input  logic [PER_W-1:0]    req_period_ms,
   input  logic                req_keep_period,
   input  logic                req_repeat_req,
   input  logic                req_restart_from_now,
   input  logic [SLOTF_W-1:0]  req_slot,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOTF_W-1:0]  rsp_slot_out,
   output logic [WAIT_W-1:0]   rsp_wait_ms,
   output logic                rsp_became_earliest,
   output logic                rsp_last
);

   // Control registers.
   fsm_type                state_ff, state_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   logic [NUM_SLOTS-1:0]   due_ff, due_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   pipe_vld_ff, pipe_vld_in;
   logic                   found_ff, found_in;
   logic [EMIT_BITS-1:0]   emit_cnt_ff, emit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [OP_W-1:0]        op_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [PERIOD_BITS-1:0] per_ff;
   logic                   keep_ff, rep_ff, restart_ff;
   logic [SLOTF_W-1:0]     slot_ff;
   logic [SLOT_BITS-1:0]   pipe_idx_ff, pipe_idx_in;
   logic [SLOT_BITS-1:0]   best_idx_ff, best_idx_in;
   entry_type              best_ent_ff, best_ent_in;
   logic [SLOT_BITS-1:0]   target_ff, target_in;
   entry_type              old_ent_ff, old_ent_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [TIME_BITS-1:0]   ne_ff, ne_in;
   rsp_type                rsp_ff, rsp_in;

   // Datapath signals.
   alu_req_type            alu_req;
   alu_res_type            alu_res;
   mem_wr_type             mem_wr;
   logic [SLOT_BITS-1:0]   mem_raddr;
   entry_type              rd_ent;
   logic [SLOT_BITS-1:0]   slot_idx;
   logic                   slot_ok;
   logic [SLOT_BITS-1:0]   free_idx;
   logic                   table_full;
   logic                   scan_done;
   logic                   scan_start;
   logic                   out_free;
   logic [PERIOD_BITS-1:0] new_period;
   logic [NUM_SLOTS-1:0]   due_left;
   logic                   upd_last;
   logic                   emit_vld;
   rsp_type                emit_rsp;
   logic                   emit_fire;
   logic                   cand;

   ott_slot_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .raddr   (mem_raddr),
      .rd_data (rd_ent)
   );

   ott_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   // Shared decode of the captured request and table status.
   always_comb begin
      slot_idx   = SLOT_BITS'(slot_ff);
      slot_ok    = (int'(slot_ff) < NUM_SLOTS) && valid_ff[slot_idx];
      table_full = &valid_ff;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SLOT_BITS'(i);
         end
      end
      scan_done  = (cnt_ff == CNT_BITS'(NUM_SLOTS)) && !pipe_vld_ff;
      out_free   = !rsp_valid_ff || rsp_ready;
      new_period = keep_ff ? old_ent_ff.period : per_ff;
      due_left   = due_ff & ~(NUM_SLOTS'(1) << best_idx_ff);
      upd_last   = (due_left == '0) || (emit_cnt_ff == EMIT_BITS'(MAX_OUT - 1));
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (op_ff)
               OP_ADD: begin
                  if (!table_full) state_in = S_ADD_WR;
                  else if (out_free) state_in = S_IDLE;
               end
               OP_CANCEL: begin
                  if (out_free) state_in = S_IDLE;
               end
               OP_RESET: begin
                  if (slot_ok) state_in = S_RST_START;
                  else if (out_free) state_in = S_IDLE;
               end
               OP_PROCESS: state_in = S_MARK;
               OP_QUERY:   state_in = S_SCAN;
               default:    state_in = S_IDLE;
            endcase
         end
         S_ADD_WR:    state_in = S_SCAN;
         S_RST_START: state_in = S_RST_SUM;
         S_RST_SUM:   state_in = S_RST_CMP;
         S_RST_CMP: begin
            if (!alu_res.eq) state_in = S_SCAN;
            else if (out_free) state_in = S_IDLE;
         end
         S_MARK: begin
            if (scan_done) state_in = S_PCHK;
         end
         S_PCHK: begin
            if (due_ff != '0) state_in = S_SCAN;
            else if (out_free) state_in = S_IDLE;
         end
         S_SCAN: begin
            if (scan_done) begin
               if (op_ff == OP_QUERY) state_in = S_QRY;
               else if (op_ff == OP_PROCESS) state_in = S_UPD;
               else state_in = S_EMIT_BE;
            end
         end
         S_EMIT_BE, S_QRY: begin
            if (out_free) state_in = S_IDLE;
         end
         S_UPD: begin
            if (out_free) state_in = upd_last ? S_IDLE : S_SCAN;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Adder operands, memory access and response selection per state.
   always_comb begin
      alu_req.op = ALU_SUB_CLAMP;
      alu_req.a  = rd_ent.expiry;
      alu_req.b  = best_ent_ff.expiry;
      mem_raddr  = cnt_ff[SLOT_BITS-1:0];
      mem_wr     = '0;
      emit_vld   = 1'b0;
      emit_rsp   = '0;
      emit_rsp.last = 1'b1;
      unique case (state_ff)
         S_DECODE: begin
            mem_raddr = slot_idx;
            emit_rsp.slot_out = slot_ff;
            if (op_ff == OP_ADD) begin
               emit_vld          = table_full;
               emit_rsp.status   = STAT_FULL;
               emit_rsp.slot_out = '0;
            end else if (op_ff == OP_CANCEL) begin
               emit_vld        = 1'b1;
               emit_rsp.status = slot_ok ? STAT_OK : STAT_NOT_ACTIVE;
            end else if (op_ff == OP_RESET) begin
               emit_vld        = !slot_ok;
               emit_rsp.status = STAT_NOT_ACTIVE;
            end
         end
         S_ADD_WR: begin
            alu_req.op  = ALU_ADD_SAT;
            alu_req.a   = now_ff;
            alu_req.b   = TIME_BITS'(per_ff);
            mem_wr.en   = 1'b1;
            mem_wr.addr = free_idx;
            mem_wr.data = '{reload: rep_ff, period: per_ff, expiry: alu_res.value};
         end
         S_RST_START: begin
            alu_req.a = rd_ent.expiry;
            alu_req.b = TIME_BITS'(rd_ent.period);
         end
         S_RST_SUM: begin
            alu_req.op = ALU_ADD_SAT;
            alu_req.a  = start_ff;
            alu_req.b  = TIME_BITS'(new_period);
         end
         S_RST_CMP: begin
            alu_req.a   = ne_ff;
            alu_req.b   = old_ent_ff.expiry;
            mem_wr.en   = 1'b1;
            mem_wr.addr = slot_idx;
            mem_wr.data = '{reload: old_ent_ff.reload, period: new_period,
                            expiry: alu_res.eq ? old_ent_ff.expiry : ne_ff};
            emit_vld          = alu_res.eq;
            emit_rsp.status   = STAT_OK;
            emit_rsp.slot_out = slot_ff;
         end
         S_MARK: begin
            alu_req.a = now_ff;
            alu_req.b = rd_ent.expiry;
         end
         S_PCHK: begin
            emit_vld        = (due_ff == '0);
            emit_rsp.status = STAT_NONE_DUE;
         end
         S_EMIT_BE: begin
            emit_vld                 = 1'b1;
            emit_rsp.status          = STAT_OK;
            emit_rsp.slot_out        = SLOTF_W'(target_ff);
            emit_rsp.became_earliest = found_ff && (best_idx_ff == target_ff);
         end
         S_QRY: begin
            alu_req.a        = best_ent_ff.expiry;
            alu_req.b        = now_ff;
            emit_vld         = 1'b1;
            emit_rsp.status  = STAT_OK;
            emit_rsp.wait_ms = WAIT_W'(found_ff ? alu_res.value : TIME_MAX);
         end
         S_UPD: begin
            alu_req.op  = ALU_ADD_SAT;
            alu_req.a   = now_ff;
            alu_req.b   = TIME_BITS'(best_ent_ff.period);
            mem_wr.en   = out_free && best_ent_ff.reload;
            mem_wr.addr = best_idx_ff;
            mem_wr.data = '{reload: best_ent_ff.reload, period: best_ent_ff.period,
                            expiry: alu_res.value};
            emit_vld          = 1'b1;
            emit_rsp.status   = STAT_OK;
            emit_rsp.slot_out = SLOTF_W'(best_idx_ff);
            emit_rsp.last     = upd_last;
         end
         default: begin
         end
      endcase
      emit_fire = emit_vld && out_free;
   end

   // Scan pipeline, slot bookkeeping and response register next values.
   always_comb begin
      scan_start  = ((state_in == S_SCAN) || (state_in == S_MARK)) && (state_in != state_ff);
      valid_in    = valid_ff;
      due_in      = due_ff;
      cnt_in      = cnt_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = cnt_ff[SLOT_BITS-1:0];
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_ent_in = best_ent_ff;
      target_in   = target_ff;
      old_ent_in  = old_ent_ff;
      start_in    = start_ff;
      ne_in       = ne_ff;
      emit_cnt_in = emit_cnt_ff;
      cand        = (op_ff == OP_PROCESS) ? due_ff[pipe_idx_ff] : valid_ff[pipe_idx_ff];

      // One slot read is issued per cycle; its data is checked in the following cycle.
      if ((state_ff == S_SCAN) || (state_ff == S_MARK)) begin
         if (cnt_ff != CNT_BITS'(NUM_SLOTS)) begin
            cnt_in      = cnt_ff + CNT_BITS'(1);
            pipe_vld_in = 1'b1;
         end
      end
      if (state_ff == S_MARK && pipe_vld_ff) begin
         due_in[pipe_idx_ff] = valid_ff[pipe_idx_ff] && !alu_res.lt;
      end
      if (state_ff == S_SCAN && pipe_vld_ff && cand && (!found_ff || alu_res.lt)) begin
         found_in    = 1'b1;
         best_idx_in = pipe_idx_ff;
         best_ent_in = rd_ent;
      end
      if (scan_start) begin
         cnt_in      = '0;
         pipe_vld_in = 1'b0;
         found_in    = 1'b0;
      end

      unique case (state_ff)
         S_DECODE: begin
            target_in   = slot_idx;
            emit_cnt_in = '0;
            if (op_ff == OP_CANCEL && slot_ok && out_free) begin
               valid_in[slot_idx] = 1'b0;
            end
         end
         S_ADD_WR: begin
            target_in          = free_idx;
            valid_in[free_idx] = 1'b1;
         end
         S_RST_START: begin
            old_ent_in = rd_ent;
            start_in   = restart_ff ? now_ff : alu_res.value;
         end
         S_RST_SUM: begin
            ne_in = alu_res.value;
         end
         S_UPD: begin
            if (out_free) begin
               emit_cnt_in = emit_cnt_ff + EMIT_BITS'(1);
               due_in      = upd_last ? '0 : due_left;
               if (!best_ent_ff.reload) begin
                  valid_in[best_idx_ff] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = emit_fire || (rsp_valid_ff && !rsp_ready);
      rsp_in       = emit_fire ? emit_rsp : rsp_ff;
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         due_ff       <= '0;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         due_ff       <= due_in;
         cnt_ff       <= cnt_in;
         pipe_vld_ff  <= pipe_vld_in;
         found_ff     <= found_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff       <= req_op;
         now_ff      <= TIME_BITS'(req_now_ms);
         per_ff      <= PERIOD_BITS'(req_period_ms);
         keep_ff     <= req_keep_period;
         rep_ff      <= req_repeat_req;
         restart_ff  <= req_restart_from_now;
         slot_ff     <= req_slot;
      end
      pipe_idx_ff <= pipe_idx_in;
      best_idx_ff <= best_idx_in;
      best_ent_ff <= best_ent_in;
      target_ff   <= target_in;
      old_ent_ff  <= old_ent_in;
      start_ff    <= start_in;
      ne_ff       <= ne_in;
      rsp_ff      <= rsp_in;
   end

   // Port drive.
   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_slot_out        = rsp_ff.slot_out;
   assign rsp_wait_ms         = rsp_ff.wait_ms;
   assign rsp_became_earliest = rsp_ff.became_earliest;
   assign rsp_last            = rsp_ff.last;

   // A slot marked expired is always an active slot.
   a_due_active: assert property (@(posedge clock) disable iff (reset)
      (due_ff & ~valid_ff) == '0)
      else $error("expired mark on a free slot");

   // The slot being emitted was selected from the expired set.
   a_upd_due: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (found_ff && due_ff[best_idx_ff]))
      else $error("emitting a slot that is not marked expired");

   // A slot reported as added is active.
   a_add_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT_BE) && (op_ff == OP_ADD)) |-> valid_ff[target_ff])
      else $error("added slot is not active");

   // The final response of a request returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_rsp.last) |=> (state_ff == S_IDLE))
      else $error("sequencer busy after final response");

   // A new request is not taken while one is in flight.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

endmodule
